// ----- rtl/core/sec_pkg.sv -----
`default_nettype none

package sec_pkg;

    localparam int INDEX_BITS     = 12;
    localparam int SHAPE_EXPONENT = 6;
    localparam int POW_STEPS      = SHAPE_EXPONENT - 1;

    localparam int REG_W  = 48;
    localparam int COMP_W = 16;
    localparam int MEAS_W = 16;

    // Q.9 position difference, Q.23 rotated value, Q.16 term
    localparam int DIFF_W = INDEX_BITS + COMP_W + 3;
    localparam int PROD_W = COMP_W + DIFF_W;
    localparam int R_W    = PROD_W + 2;
    localparam int A9_W   = 21;
    localparam int T_W    = 21;
    localparam int SUM_W  = T_W + 2;

    localparam logic [T_W-1:0]   TERM_CAP = T_W'(1) << 20;
    localparam logic [SUM_W-1:0] Q16_ONE  = SUM_W'(65536);

    // pipeline stage map
    localparam int AXIS_FIRST  = 3;
    localparam int AXIS_STAGES = POW_STEPS + 2;
    localparam int NUM_STAGES  = AXIS_FIRST + AXIS_STAGES + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_CENTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_ROW_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_ROW_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_ROW_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SEMI     = 3'd6;

    localparam logic [REG_W-1:0] RST_ORIENT_ROW_X = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] RST_ORIENT_ROW_Y = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] RST_ORIENT_ROW_Z = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] RST_INV_SEMI     = 48'h0100_0100_0100;

    typedef struct packed {
        logic signed [INDEX_BITS-1:0] cell_i;
        logic signed [INDEX_BITS-1:0] cell_j;
        logic signed [INDEX_BITS-1:0] cell_k;
    } t_in_item;

    typedef struct packed {
        logic              inside_res;
        logic [MEAS_W-1:0] shape_measure;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/sec_axis_term.sv -----
`default_nettype none

// One axis: |r| rounded to Q.9, scaled by the reciprocal, then raised to
// the shape exponent by one multiply per stage.
module sec_axis_term (
    input  wire logic                                   i_clk,
    input  wire logic [sec_pkg::AXIS_STAGES-1:0]        i_en,
    input  wire logic signed [sec_pkg::R_W-1:0]         i_r,
    input  wire logic [sec_pkg::COMP_W-1:0]             i_inv,
    output logic [sec_pkg::T_W-1:0]                     o_term
);

    localparam int U_W = sec_pkg::A9_W + sec_pkg::COMP_W;
    localparam int P_W = 2 * sec_pkg::T_W;
    localparam int Q_W = P_W - 16;

    logic [sec_pkg::R_W-1:0]  mag;
    logic [sec_pkg::R_W-1:0]  mag_rnd;
    logic [sec_pkg::A9_W-1:0] n_a9;
    logic                     n_big;
    logic [sec_pkg::A9_W-1:0] r_a9;
    logic                     r_big;

    logic [U_W-1:0]            u;
    logic [sec_pkg::A9_W:0]    u_rnd;
    logic [sec_pkg::T_W-1:0]   n_t;
    logic [sec_pkg::T_W-1:0]   r_t;

    logic [sec_pkg::T_W-1:0] r_p  [sec_pkg::POW_STEPS];
    logic [sec_pkg::T_W-1:0] r_tc [sec_pkg::POW_STEPS];

    always_comb begin
        mag     = i_r[sec_pkg::R_W-1] ? sec_pkg::R_W'(-i_r) : sec_pkg::R_W'(i_r);
        mag_rnd = mag + (sec_pkg::R_W'(1) << 13);
        n_a9    = mag_rnd[14 +: sec_pkg::A9_W];
        n_big   = |mag_rnd[sec_pkg::R_W-1:14+sec_pkg::A9_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a9  <= n_a9;
            r_big <= n_big;
        end
    end

    // a capped scale factor saturates every power at the cap
    always_comb begin
        u     = U_W'(r_a9) * U_W'(i_inv);
        u_rnd = u[sec_pkg::A9_W-1:0] + (sec_pkg::A9_W+1)'(1);
        if ((r_big && (i_inv != '0)) || (|u[U_W-1:sec_pkg::A9_W])) begin
            n_t = sec_pkg::TERM_CAP;
        end else begin
            n_t = u_rnd[sec_pkg::A9_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t <= n_t;
        end
    end

    for (genvar k = 0; k < sec_pkg::POW_STEPS; k++) begin : g_pow
        logic [sec_pkg::T_W-1:0] p_in;
        logic [sec_pkg::T_W-1:0] t_in;
        logic [P_W-1:0]          prod;
        logic [P_W-1:0]          prod_rnd;
        logic [Q_W-1:0]          q;
        logic [sec_pkg::T_W-1:0] n_p;

        if (k == 0) begin : g_first
            assign p_in = r_t;
            assign t_in = r_t;
        end else begin : g_next
            assign p_in = r_p[k-1];
            assign t_in = r_tc[k-1];
        end

        always_comb begin
            prod     = P_W'(p_in) * P_W'(t_in);
            prod_rnd = prod + (P_W'(1) << 15);
            q        = prod_rnd[P_W-1:16];
            n_p      = (q > Q_W'(sec_pkg::TERM_CAP)) ? sec_pkg::TERM_CAP
                                                     : q[sec_pkg::T_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k+2]) begin
                r_p[k]  <= n_p;
                r_tc[k] <= t_in;
            end
        end
    end

    if (sec_pkg::POW_STEPS > 0) begin : g_out_pow
        assign o_term = r_p[sec_pkg::POW_STEPS-1];
    end else begin : g_out_lin
        assign o_term = r_t;
    end

endmodule

`default_nettype wire

// ----- rtl/core/superellipsoid_cell_inside_test.sv -----
// Superellipsoid cell inside test.
// Input channel (i_in_valid/o_in_ready, i_in_data) takes one cell index
// triple per transaction; output channel (o_out_valid/i_out_ready,
// o_out_data) returns one inside flag and Q4.12 shape measure per cell,
// in order.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index,
// i_cfg_data) writes one of seven 48-bit registers; o_cfg_ready is always
// high and indexes past the last register are dropped. Write only while
// the pipeline is empty.
// Throughput: one cell per clock while the receiver keeps i_out_ready
// high, set by the fully pipelined datapath: position, 9 matrix
// multiplies, rotation sum, rounding, reciprocal scale, five power
// multiplies per axis, final sum.
// Each stage carries its own valid bit and holds only while full and
// blocked downstream, so empty slots close up behind a stalled result and
// inputs keep flowing until every stage is full.
// Reset (synchronous, active low) empties the pipeline and loads the
// default registers: zero geometry, identity orientation, unit reciprocals.
`default_nettype none

module superellipsoid_cell_inside_test (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire sec_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output sec_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sec_pkg::REG_W-1:0]         i_cfg_data
);

    localparam int NS   = sec_pkg::NUM_STAGES;
    localparam int CW   = sec_pkg::COMP_W;
    localparam int MW   = sec_pkg::INDEX_BITS + CW + 2;

    logic [sec_pkg::REG_W-1:0] r_cell_size;
    logic [sec_pkg::REG_W-1:0] r_domain_low;
    logic [sec_pkg::REG_W-1:0] r_body_center;
    logic [sec_pkg::REG_W-1:0] r_row [3];
    logic [sec_pkg::REG_W-1:0] r_inv_semi;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    logic signed [sec_pkg::INDEX_BITS-1:0] idx [3];
    logic signed [sec_pkg::DIFF_W-1:0]     n_d [3];
    logic signed [sec_pkg::DIFF_W-1:0]     r_d [3];
    logic signed [sec_pkg::PROD_W-1:0]     r_pr [3][3];
    logic signed [sec_pkg::R_W-1:0]        r_r [3];
    logic [sec_pkg::T_W-1:0]               term [3];

    logic [sec_pkg::SUM_W-1:0] sum;
    logic [sec_pkg::SUM_W-1:0] meas_rnd;
    logic [sec_pkg::SUM_W-5:0] meas_q;
    sec_pkg::t_out_item        n_out;
    sec_pkg::t_out_item        r_out;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size   <= '0;
            r_domain_low  <= '0;
            r_body_center <= '0;
            r_row[0]      <= sec_pkg::RST_ORIENT_ROW_X;
            r_row[1]      <= sec_pkg::RST_ORIENT_ROW_Y;
            r_row[2]      <= sec_pkg::RST_ORIENT_ROW_Z;
            r_inv_semi    <= sec_pkg::RST_INV_SEMI;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sec_pkg::CFG_CELL_SIZE:    r_cell_size   <= i_cfg_data;
                sec_pkg::CFG_DOMAIN_LOW:   r_domain_low  <= i_cfg_data;
                sec_pkg::CFG_BODY_CENTER:  r_body_center <= i_cfg_data;
                sec_pkg::CFG_ORIENT_ROW_X: r_row[0]      <= i_cfg_data;
                sec_pkg::CFG_ORIENT_ROW_Y: r_row[1]      <= i_cfg_data;
                sec_pkg::CFG_ORIENT_ROW_Z: r_row[2]      <= i_cfg_data;
                sec_pkg::CFG_INV_SEMI:     r_inv_semi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    assign en[NS-1] = ~r_v[NS-1] | i_out_ready;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign en[s] = ~r_v[s] | en[s+1];
    end
    assign o_in_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage 0: cell centre minus body centre, Q.9
    assign idx[0] = i_in_data.cell_i;
    assign idx[1] = i_in_data.cell_j;
    assign idx[2] = i_in_data.cell_k;

    for (genvar a = 0; a < 3; a++) begin : g_pos
        logic signed [sec_pkg::INDEX_BITS:0] idx2p1;
        logic signed [CW:0]                  cs;
        logic signed [MW-1:0]                m;
        logic signed [CW:0]                  dl2;
        logic signed [CW:0]                  bc2;

        always_comb begin
            idx2p1 = {idx[a], 1'b1};
            cs     = {1'b0, r_cell_size[CW*a +: CW]};
            m      = MW'(idx2p1) * MW'(cs);
            dl2    = {r_domain_low[CW*a +: CW], 1'b0};
            bc2    = {r_body_center[CW*a +: CW], 1'b0};
            n_d[a] = sec_pkg::DIFF_W'(m) + sec_pkg::DIFF_W'(dl2)
                   - sec_pkg::DIFF_W'(bc2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d <= n_d;
        end
    end

    // stage 1: matrix products; stage 2: row sums
    for (genvar a = 0; a < 3; a++) begin : g_rot
        for (genvar b = 0; b < 3; b++) begin : g_col
            logic signed [CW-1:0] coef;
            assign coef = r_row[a][CW*b +: CW];

            always_ff @(posedge i_clk) begin
                if (en[1]) begin
                    r_pr[a][b] <= sec_pkg::PROD_W'(coef) * sec_pkg::PROD_W'(r_d[b]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[2]) begin
                r_r[a] <= sec_pkg::R_W'(r_pr[a][0]) + sec_pkg::R_W'(r_pr[a][1])
                        + sec_pkg::R_W'(r_pr[a][2]);
            end
        end

        sec_axis_term u_axis (
            .i_clk  (i_clk),
            .i_en   (en[sec_pkg::AXIS_FIRST +: sec_pkg::AXIS_STAGES]),
            .i_r    (r_r[a]),
            .i_inv  (r_inv_semi[CW*a +: CW]),
            .o_term (term[a])
        );
    end

    // last stage: sum, flag and saturated measure
    always_comb begin
        sum      = sec_pkg::SUM_W'(term[0]) + sec_pkg::SUM_W'(term[1])
                 + sec_pkg::SUM_W'(term[2]);
        meas_rnd = sum + sec_pkg::SUM_W'(8);
        meas_q   = meas_rnd[sec_pkg::SUM_W-1:4];
        n_out.inside_res    = (sum <= sec_pkg::Q16_ONE);
        n_out.shape_measure = (|meas_q[sec_pkg::SUM_W-5:sec_pkg::MEAS_W])
                            ? '1 : meas_q[sec_pkg::MEAS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v[NS-1];
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

    // no register behind this index
    localparam logic [sec_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam longint unsigned TERM_LIMIT = 64'd1048576;  // 16.0 in Q.16
    localparam longint unsigned UNIT_Q16 = 64'd65536;
    localparam int CYCLE_LIMIT = 400000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    sec_pkg::t_in_item             in_data = '0;
    logic                          out_ready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [sec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sec_pkg::REG_W-1:0]     cfg_data = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    sec_pkg::t_out_item            o_out_data;
    logic                          o_cfg_ready;

    logic [sec_pkg::REG_W-1:0] geom_reg [0:6];
    sec_pkg::t_in_item         pending_cells [$];
    sec_pkg::t_out_item        verdict_q [$];
    sec_pkg::t_out_item        want;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               index_span = 8;
    int               cells_pushed = 0;
    int               results_seen = 0;
    int               mismatch_count = 0;
    int               reg_writes = 0;
    int               settings_used = 0;
    int               cycle_count = 0;

    superellipsoid_cell_inside_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint comp_s(logic [sec_pkg::REG_W-1:0] r, int a);
        logic signed [sec_pkg::COMP_W-1:0] v;
        v = r[sec_pkg::COMP_W*a +: sec_pkg::COMP_W];
        return v;
    endfunction

    function automatic longint comp_u(logic [sec_pkg::REG_W-1:0] r, int a);
        return longint'(r[sec_pkg::COMP_W*a +: sec_pkg::COMP_W]);
    endfunction

    // rotated value in Q.23 -> one axis power term in Q.16
    function automatic longint unsigned axis_term(longint rot, longint unsigned recip);
        longint unsigned mag;
        longint unsigned t;
        longint unsigned p;
        int e;
        mag = (rot < 0) ? -rot : rot;
        mag = (mag + 64'd8192) >> 14;
        mag = mag * recip;
        if (mag >= 64'd2097152) begin
            return TERM_LIMIT;
        end
        t = (mag + 64'd1) >> 1;
        p = t;
        for (e = 1; e < sec_pkg::SHAPE_EXPONENT; e++) begin
            p = (p * t + 64'd32768) >> 16;
            if (p > TERM_LIMIT) begin
                p = TERM_LIMIT;
            end
        end
        return p;
    endfunction

    function automatic sec_pkg::t_out_item eval_superellipsoid(sec_pkg::t_in_item c);
        longint idx [3];
        longint d [3];
        longint rot;
        longint unsigned total;
        longint unsigned meas;
        sec_pkg::t_out_item res;
        int a;
        int b;
        idx[0] = $signed(c.cell_i);
        idx[1] = $signed(c.cell_j);
        idx[2] = $signed(c.cell_k);
        for (a = 0; a < 3; a++) begin
            // cell center relative to the body, Q.9
            d[a] = 2 * comp_s(geom_reg[sec_pkg::CFG_DOMAIN_LOW], a)
                 + (2 * idx[a] + 1) * comp_u(geom_reg[sec_pkg::CFG_CELL_SIZE], a)
                 - 2 * comp_s(geom_reg[sec_pkg::CFG_BODY_CENTER], a);
        end
        total = 0;
        for (a = 0; a < 3; a++) begin
            rot = 0;
            for (b = 0; b < 3; b++) begin
                rot += comp_s(geom_reg[sec_pkg::CFG_ORIENT_ROW_X + a], b) * d[b];
            end
            total += axis_term(rot, comp_u(geom_reg[sec_pkg::CFG_INV_SEMI], a));
        end
        meas = (total + 64'd8) >> 4;
        if (meas > 64'd65535) begin
            meas = 64'd65535;
        end
        res.inside_res = (total <= UNIT_Q16);
        res.shape_measure = meas[sec_pkg::MEAS_W-1:0];
        return res;
    endfunction

    // driver: predict on every accepted transaction, then load the next cell
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                verdict_q.push_back(eval_superellipsoid(in_data));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data <= pending_cells.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                $error("unexpected result: inside_res=%0b shape_measure=%0d",
                       o_out_data.inside_res, o_out_data.shape_measure);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.inside_res !== want.inside_res) begin
                    $error("inside_res: expected %0b, got %0b",
                           want.inside_res, o_out_data.inside_res);
                    mismatch_count++;
                end
                if (o_out_data.shape_measure !== want.shape_measure) begin
                    $error("shape_measure: expected %0d, got %0d",
                           want.shape_measure, o_out_data.shape_measure);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d of %0d results", results_seen, cells_pushed);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [sec_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sec_pkg::REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= sec_pkg::CFG_INV_SEMI) begin
            geom_reg[idx] = val;
        end
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic queue_cell(input int i, input int j, input int k);
        sec_pkg::t_in_item c;
        c.cell_i = 12'(i);
        c.cell_j = 12'(j);
        c.cell_k = 12'(k);
        pending_cells.push_back(c);
        cells_pushed++;
    endtask

    task automatic queue_random_cells(input int n);
        logic [63:0] raw;
        int m;
        for (m = 0; m < n; m++) begin
            if ($urandom_range(99) < 15) begin
                raw = {$urandom, $urandom};
                pending_cells.push_back(
                    sec_pkg::t_in_item'(raw[$bits(sec_pkg::t_in_item)-1:0]));
                cells_pushed++;
            end else begin
                queue_cell(int'($urandom_range(2 * index_span)) - index_span,
                           int'($urandom_range(2 * index_span)) - index_span,
                           int'($urandom_range(2 * index_span)) - index_span);
            end
        end
    endtask

    task automatic wait_results();
        while (results_seen != cells_pushed) @(posedge i_clk);
    endtask

    // wild: every register random; otherwise the body sits near the indexed cells and
    // semi-axes are sized to the index span so cells land on both sides of the surface
    task automatic load_random_geometry(input bit wild);
        logic [sec_pkg::REG_W-1:0] cs;
        logic [sec_pkg::REG_W-1:0] dl;
        logic [sec_pkg::REG_W-1:0] bc;
        logic [sec_pkg::REG_W-1:0] inv;
        logic [sec_pkg::REG_W-1:0] rows [3];
        logic [63:0] raw;
        int unsigned c;
        int unsigned recip;
        int a;
        int b;
        settings_used++;
        if (wild) begin
            index_span = 2047;
            for (a = 0; a <= sec_pkg::CFG_INV_SEMI; a++) begin
                raw = {$urandom, $urandom};
                write_reg(sec_pkg::CFG_CELL_SIZE + sec_pkg::CFG_IDX_W'(a),
                          raw[sec_pkg::REG_W-1:0]);
            end
        end else begin
            index_span = $urandom_range(8, 128);
            for (a = 0; a < 3; a++) begin
                c = $urandom_range(4, 64);
                cs[sec_pkg::COMP_W*a +: sec_pkg::COMP_W] = sec_pkg::COMP_W'(c);
                recip = (131072 / (index_span * c)) * $urandom_range(50, 200) / 100;
                if (recip == 0) begin
                    recip = 1;
                end
                inv[sec_pkg::COMP_W*a +: sec_pkg::COMP_W] = sec_pkg::COMP_W'(recip);
                dl[sec_pkg::COMP_W*a +: sec_pkg::COMP_W] =
                    sec_pkg::COMP_W'($urandom_range(2047)) - 16'd1024;
                bc[sec_pkg::COMP_W*a +: sec_pkg::COMP_W] =
                    dl[sec_pkg::COMP_W*a +: sec_pkg::COMP_W]
                    + sec_pkg::COMP_W'($urandom_range(8 * c)) - sec_pkg::COMP_W'(4 * c);
                for (b = 0; b < 3; b++) begin
                    rows[a][sec_pkg::COMP_W*b +: sec_pkg::COMP_W] =
                        sec_pkg::COMP_W'($urandom_range(32768)) - 16'h4000;
                end
            end
            write_reg(sec_pkg::CFG_CELL_SIZE, cs);
            write_reg(sec_pkg::CFG_DOMAIN_LOW, dl);
            write_reg(sec_pkg::CFG_BODY_CENTER, bc);
            write_reg(sec_pkg::CFG_ORIENT_ROW_X, rows[0]);
            write_reg(sec_pkg::CFG_ORIENT_ROW_Y, rows[1]);
            write_reg(sec_pkg::CFG_ORIENT_ROW_Z, rows[2]);
            write_reg(sec_pkg::CFG_INV_SEMI, inv);
        end
    endtask

    initial begin
        int phase;
        geom_reg[sec_pkg::CFG_CELL_SIZE] = '0;
        geom_reg[sec_pkg::CFG_DOMAIN_LOW] = '0;
        geom_reg[sec_pkg::CFG_BODY_CENTER] = '0;
        geom_reg[sec_pkg::CFG_ORIENT_ROW_X] = sec_pkg::RST_ORIENT_ROW_X;
        geom_reg[sec_pkg::CFG_ORIENT_ROW_Y] = sec_pkg::RST_ORIENT_ROW_Y;
        geom_reg[sec_pkg::CFG_ORIENT_ROW_Z] = sec_pkg::RST_ORIENT_ROW_Z;
        geom_reg[sec_pkg::CFG_INV_SEMI] = sec_pkg::RST_INV_SEMI;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 28;
        recv_idle_pct = 62;

        // reset geometry: zero cell size puts every cell on the body center
        settings_used++;
        queue_cell(0, 0, 0);
        queue_cell(2047, -2048, 1);
        wait_results();

        // unit cells along x, x semi-axis 0.5: cells 0 and -1 sit exactly on the surface
        settings_used++;
        write_reg(sec_pkg::CFG_CELL_SIZE, 48'h0000_0000_0100);
        write_reg(sec_pkg::CFG_DOMAIN_LOW, '0);
        write_reg(sec_pkg::CFG_BODY_CENTER, '0);
        write_reg(sec_pkg::CFG_ORIENT_ROW_X, sec_pkg::RST_ORIENT_ROW_X);
        write_reg(sec_pkg::CFG_ORIENT_ROW_Y, sec_pkg::RST_ORIENT_ROW_Y);
        write_reg(sec_pkg::CFG_ORIENT_ROW_Z, sec_pkg::RST_ORIENT_ROW_Z);
        write_reg(sec_pkg::CFG_INV_SEMI, 48'h0100_0100_0200);
        write_reg(CFG_SPARE, '1);  // must not land anywhere
        queue_cell(0, 0, 0);
        queue_cell(-1, 0, 0);
        queue_cell(1, 0, 0);
        queue_cell(2047, 0, 0);
        queue_cell(-2048, 5, -7);
        queue_cell(0, 2047, -2048);
        wait_results();

        // extreme register contents, zero reciprocal on y
        settings_used++;
        write_reg(sec_pkg::CFG_CELL_SIZE, 48'h0010_FFFF_0008);
        write_reg(sec_pkg::CFG_DOMAIN_LOW, 48'h8000_7FFF_FF00);
        write_reg(sec_pkg::CFG_BODY_CENTER, 48'h7FFF_8000_0100);
        write_reg(sec_pkg::CFG_ORIENT_ROW_X, 48'h0000_8000_7FFF);
        write_reg(sec_pkg::CFG_ORIENT_ROW_Y, 48'h4000_C000_2000);
        write_reg(sec_pkg::CFG_ORIENT_ROW_Z, 48'hFFFF_0001_0000);
        write_reg(sec_pkg::CFG_INV_SEMI, 48'hFFFF_0000_0001);
        for (phase = 0; phase < 8; phase++) begin
            queue_cell(phase[0] ? 2047 : -2048, phase[1] ? 2047 : -2048,
                       phase[2] ? 2047 : -2048);
        end
        queue_cell(0, 0, 0);
        queue_cell(-1, -1, -1);
        wait_results();

        for (phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 62;
                end
                1: begin
                    send_idle_pct = 62;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_random_geometry(phase == 3);
            queue_random_cells(100);
            wait_results();
        end

        repeat (16) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $error("%0d results never arrived", verdict_q.size());
            mismatch_count++;
        end
        $display("checked %0d cells over %0d geometry settings, %0d register writes",
                 results_seen, settings_used, reg_writes);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- superellipsoid_cell_inside_test.f -----
rtl/core/sec_pkg.sv
rtl/core/sec_axis_term.sv
rtl/core/superellipsoid_cell_inside_test.sv
test/tb.sv
